// ===== rtl/uid_hash_packet_classifier_macros.svh =====
// Assertion macros for the uid hash packet classifier.
// Used by the port checker; depends on nothing else.
`ifndef UID_HASH_PACKET_CLASSIFIER_MACROS_SVH
`define UID_HASH_PACKET_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define UHPC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UHPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/uhpc_pkg.sv =====
// Shared types, constants and address checks for the uid hash packet classifier.
// No dependencies.
`timescale 1ns / 1ps
package uhpc_pkg;

   localparam int TableDepthDefault = 256;
   localparam int ProbeLimitDefault = 8;
   localparam int QueueDepth        = 2;
   localparam int ReduceBits        = 4;
   localparam int ReduceSteps       = 32 / ReduceBits;

   localparam logic [31:0] HASH_MULT    = 32'h9e37_79b1;
   localparam logic [31:0] EXCLUDED_UID = 32'd65534;
   localparam logic [7:0]  PROTO_TCP    = 8'd6;
   localparam logic [7:0]  PROTO_UDP    = 8'd17;

   localparam logic [1:0] CSR_LIVE           = 2'd0;
   localparam logic [1:0] CSR_HANDOFF_MODE   = 2'd1;
   localparam logic [1:0] CSR_LISTENER_READY = 2'd2;

   localparam logic [1:0] MODE_CLASSIFY_ONLY = 2'd0;
   localparam logic [1:0] MODE_NO_LISTENER   = 2'd1;

   typedef enum logic [1:0] {
      OP_CLEAR    = 2'd0,
      OP_INSERT   = 2'd1,
      OP_CLASSIFY = 2'd2,
      OP_NOP      = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      R_NOT_LIVE      = 4'd0,
      R_NO_SOCKET     = 4'd1,
      R_EXCLUDED      = 4'd2,
      R_NOT_SELECTED  = 4'd3,
      R_RESERVED      = 4'd4,
      R_CLASSIFY_ONLY = 4'd5,
      R_PROTO         = 4'd6,
      R_NO_LISTENER   = 4'd7,
      R_QUEUE_FULL    = 4'd8,
      R_STOLEN        = 4'd9,
      R_TABLE_OP      = 4'd10
   } reason_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] user_id;
      logic        has_full_socket;
      logic        is_ipv6;
      logic [63:0] dest_high;
      logic [63:0] dest_low;
      logic [7:0]  transport_proto;
      logic        queue_full;
   } req_type;

   typedef struct packed {
      logic        steal;
      logic [3:0]  reason;
      logic        insert_no_space;
      logic [63:0] selected_total;
   } rsp_type;

   typedef struct packed {
      logic       live;
      logic [1:0] handoff_mode;
      logic       listener_ready;
   } cfg_type;

   // decoded request as it travels from front to back (slot goes alongside)
   typedef struct packed {
      opcode_type  op;
      logic [31:0] uid;
      logic        has_socket;
      logic        excluded;
      logic        reserved;
      logic        proto_ok;
      logic        queue_full;
   } item_type;

   function automatic logic reserved_v4(input logic [31:0] a);
      logic r;
      r = (a[31:24] == 8'h00) || (a[31:24] == 8'h0a) || (a[31:24] == 8'h7f)
       || (a[31:16] == 16'ha9fe) || (a[31:20] == 12'hac1)
       || (a[31:16] == 16'hc0a8) || (a[31:28] == 4'he)
       || (a == 32'hffff_ffff) || (a == 32'hc633_6401);
      return r;
   endfunction

   function automatic logic reserved_v6(input logic [63:0] hi, input logic [63:0] lo);
      logic r;
      r = ((hi == 64'd0) && ((lo == 64'd0) || (lo == 64'd1)))
       || (hi[63:57] == 7'b1111_110)
       || (hi[63:54] == 10'b1111_1110_10)
       || (hi[63:56] == 8'hff)
       || ((hi == 64'h2001_0db8_0000_0001) && (lo == 64'd2));
      return r;
   endfunction

endpackage

// ===== rtl/uhpc_front.sv =====
// Front end: takes requests, decodes the check flags and works out the home slot.
// Depends on uhpc_pkg.
`timescale 1ns / 1ps
module uhpc_front import uhpc_pkg::*; #(
   parameter int TABLE_DEPTH = TableDepthDefault,
   localparam int AW = $clog2(TABLE_DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   output logic          push_valid,
   input  logic          push_ready,
   output item_type      push_item,
   output logic [AW-1:0] push_slot
);

   localparam bit POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);
   localparam int SW   = $clog2(ReduceSteps);

   typedef enum logic [3:0] {
      F_IDLE   = 4'b0001,
      F_HASH   = 4'b0010,
      F_REDUCE = 4'b0100,
      F_PUSH   = 4'b1000
   } fstate_type;

   fstate_type    state_ff, state_in;
   item_type      item_ff, item_in;
   logic [31:0]   prod_ff, prod_in;
   logic [AW-1:0] rem_ff, rem_in;
   logic [SW-1:0] step_ff, step_in;
   logic [63:0]   prod_full;
   logic [AW:0]   red_t;
   logic [AW-1:0] red_r;

   assign req_ready  = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign push_item  = item_ff;
   assign push_slot  = POW2 ? prod_ff[AW-1:0] : rem_ff;
   assign prod_full  = item_ff.uid * HASH_MULT;

   // four bits of the hash folded into the remainder per cycle
   always_comb begin
      red_r = rem_ff;
      red_t = '0;
      for (int j = 0; j < ReduceBits; j++) begin
         red_t = {red_r, prod_ff[31 - j]};
         if (red_t >= (AW + 1)'(TABLE_DEPTH)) begin
            red_t = red_t - (AW + 1)'(TABLE_DEPTH);
         end
         red_r = red_t[AW-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               item_in.op         = opcode_type'(req_data.opcode);
               item_in.uid        = req_data.user_id;
               item_in.has_socket = req_data.has_full_socket;
               item_in.excluded   = (req_data.user_id == 32'd0)
                                 || (req_data.user_id == EXCLUDED_UID);
               item_in.reserved   = req_data.is_ipv6
                                  ? reserved_v6(req_data.dest_high, req_data.dest_low)
                                  : reserved_v4(req_data.dest_low[31:0]);
               item_in.proto_ok   = (req_data.transport_proto == PROTO_TCP)
                                 || (req_data.transport_proto == PROTO_UDP);
               item_in.queue_full = req_data.queue_full;
               state_in           = F_HASH;
            end
         end
         F_HASH: begin
            prod_in  = prod_full[31:0];
            rem_in   = '0;
            step_in  = '0;
            state_in = POW2 ? F_PUSH : F_REDUCE;
         end
         F_REDUCE: begin
            rem_in  = red_r;
            prod_in = {prod_ff[31-ReduceBits:0], {ReduceBits{1'b0}}};
            step_in = step_ff + 1'b1;
            if (step_ff == SW'(ReduceSteps - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      item_ff <= item_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

endmodule

// ===== rtl/uhpc_queue.sv =====
// Small FIFO between the front end and the table engine.
// Depends on uhpc_pkg for the default depth.
`timescale 1ns / 1ps
module uhpc_queue import uhpc_pkg::*; #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = QueueDepth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output logic [DATA_WIDTH-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]         wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/uhpc_back.sv =====
// Table engine: uid table memory, probe sequencer, clear sweep, selected count
// and the response register. Depends on uhpc_pkg.
`timescale 1ns / 1ps
module uhpc_back import uhpc_pkg::*; #(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int PROBE_LIMIT = ProbeLimitDefault,
   localparam int AW = $clog2(TABLE_DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  item_type      pop_item,
   input  logic [AW-1:0] pop_slot,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);

   localparam int KW = $clog2(PROBE_LIMIT + 1);

   typedef enum logic [3:0] {
      B_CLEAR = 4'b0001,
      B_IDLE  = 4'b0010,
      B_LOOK  = 4'b0100,
      B_DONE  = 4'b1000
   } bstate_type;

   logic [31:0]   mem [TABLE_DEPTH];
   logic [31:0]   rd_data_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [31:0]   wr_data;
   logic          wr_en;

   bstate_type    state_ff, state_in;
   item_type      item_ff, item_in;
   logic [AW-1:0] idx_ff, idx_in, next_idx;
   logic [KW-1:0] probe_ff, probe_in;
   logic          hit_ff, hit_in, nospace_ff, nospace_in;
   logic          clr_op_ff, clr_op_in;
   logic [63:0]   count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   rsp_type       result;
   logic          count_inc, need_look, out_free, match, empty;

   assign pop_ready = (state_ff == B_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign next_idx  = (idx_ff == AW'(TABLE_DEPTH - 1)) ? '0 : idx_ff + 1'b1;
   assign match     = (rd_data_ff == item_ff.uid);
   assign empty     = (rd_data_ff == 32'd0);
   assign need_look = !pop_item.excluded
                   && ((pop_item.op == OP_INSERT)
                    || ((pop_item.op == OP_CLASSIFY) && cfg.live && pop_item.has_socket));

   // decision chain once the lookup is settled
   always_comb begin
      result                 = '0;
      result.reason          = R_TABLE_OP;
      result.insert_no_space = (item_ff.op == OP_INSERT) && nospace_ff;
      count_inc              = 1'b0;
      if (item_ff.op == OP_CLASSIFY) begin
         if (!cfg.live) begin
            result.reason = R_NOT_LIVE;
         end else if (!item_ff.has_socket) begin
            result.reason = R_NO_SOCKET;
         end else if (item_ff.excluded) begin
            result.reason = R_EXCLUDED;
         end else if (!hit_ff) begin
            result.reason = R_NOT_SELECTED;
         end else if (item_ff.reserved) begin
            result.reason = R_RESERVED;
         end else begin
            count_inc = 1'b1;
            if (cfg.handoff_mode == MODE_CLASSIFY_ONLY) begin
               result.reason = R_CLASSIFY_ONLY;
            end else if (!item_ff.proto_ok) begin
               result.reason = R_PROTO;
            end else if ((cfg.handoff_mode != MODE_NO_LISTENER) && !cfg.listener_ready) begin
               result.reason = R_NO_LISTENER;
            end else if (item_ff.queue_full) begin
               result.reason = R_QUEUE_FULL;
            end else begin
               result.reason = R_STOLEN;
               result.steal  = 1'b1;
            end
         end
      end
      result.selected_total = count_ff + {63'd0, count_inc};
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      idx_in       = idx_ff;
      probe_in     = probe_ff;
      hit_in       = hit_ff;
      nospace_in   = nospace_ff;
      clr_op_in    = clr_op_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rd_addr      = next_idx;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = item_ff.uid;
      unique case (state_ff)
         B_CLEAR: begin
            // one entry a cycle; idx doubles as the sweep address
            wr_en   = 1'b1;
            wr_data = 32'd0;
            idx_in  = next_idx;
            if (idx_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = clr_op_ff ? B_DONE : B_IDLE;
            end
         end
         B_IDLE: begin
            rd_addr = pop_slot;
            if (pop_valid) begin
               item_in    = pop_item;
               idx_in     = pop_slot;
               probe_in   = '0;
               hit_in     = 1'b0;
               nospace_in = 1'b0;
               if (pop_item.op == OP_CLEAR) begin
                  clr_op_in = 1'b1;
                  idx_in    = '0;
                  state_in  = B_CLEAR;
               end else if (need_look) begin
                  state_in = B_LOOK;
               end else begin
                  state_in = B_DONE;
               end
            end
         end
         B_LOOK: begin
            if (match || empty) begin
               hit_in   = match;
               wr_en    = (item_ff.op == OP_INSERT);
               state_in = B_DONE;
            end else if (probe_ff == KW'(PROBE_LIMIT - 1)) begin
               nospace_in = 1'b1;
               state_in   = B_DONE;
            end else begin
               idx_in   = next_idx;
               probe_in = probe_ff + 1'b1;
            end
         end
         B_DONE: begin
            if (out_free) begin
               rsp_in       = result;
               rsp_valid_in = 1'b1;
               count_in     = result.selected_total;
               clr_op_in    = 1'b0;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         idx_ff       <= '0;
         clr_op_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         clr_op_ff    <= clr_op_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff    <= item_in;
      probe_ff   <= probe_in;
      hit_ff     <= hit_in;
      nospace_ff <= nospace_in;
      rsp_ff     <= rsp_in;
   end

endmodule

// ===== rtl/uid_hash_packet_classifier.sv =====
// Top level of the uid hash packet classifier: control registers, front end,
// request queue and table engine. Depends on uhpc_pkg and the uhpc_* modules.
`timescale 1ns / 1ps
// Keeps a set of selected uids in a TABLE_DEPTH-entry table (home slot: low
// 32 bits of uid*0x9e3779b1 modulo TABLE_DEPTH, linear probing over up to
// PROBE_LIMIT slots) and answers each request with one response: clear,
// insert, no-op or a packet verdict. After reset the table is swept to zero,
// all TABLE_DEPTH entries (256 by default), before the first request is
// served; a clear request takes the same sweep. The front end steps through
// idle, hash and push, with a reduce step before push when TABLE_DEPTH is not
// a power of two (the slot is reduced four hash bits per cycle), and takes no
// new request until the last is pushed. The table engine does one table read
// per probed slot. A two-entry queue lets the front end take the next request
// while the engine probes, and a response register holds a result until taken.
module uid_hash_packet_classifier import uhpc_pkg::*; #(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int PROBE_LIMIT = ProbeLimitDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [1:0] csr_wdata
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int QW = AW + $bits(item_type);

   cfg_type       cfg_ff, cfg_in;
   logic          push_valid, push_ready, pop_valid, pop_ready;
   item_type      push_item, pop_item;
   logic [AW-1:0] push_slot, pop_slot;
   logic [QW-1:0] q_out;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LIVE:           cfg_in.live           = csr_wdata[0];
            CSR_HANDOFF_MODE:   cfg_in.handoff_mode   = csr_wdata;
            CSR_LISTENER_READY: cfg_in.listener_ready = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   uhpc_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .push_slot  (push_slot)
   );

   uhpc_queue #(.DATA_WIDTH(QW), .DEPTH(QueueDepth)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_slot, push_item}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (q_out)
   );

   assign pop_slot = q_out[QW-1 -: AW];
   assign pop_item = item_type'(q_out[$bits(item_type)-1:0]);

   uhpc_back #(.TABLE_DEPTH(TABLE_DEPTH), .PROBE_LIMIT(PROBE_LIMIT)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .pop_slot  (pop_slot),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/uhpc_checker.sv =====
// Port checker for the uid hash packet classifier, bound to the top level.
// Depends on uhpc_pkg and uid_hash_packet_classifier_macros.svh.
`timescale 1ns / 1ps
`include "uid_hash_packet_classifier_macros.svh"
module uhpc_checker import uhpc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input req_type    req_data,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input rsp_type    rsp_data,
   input logic       csr_write_enable,
   input logic [1:0] csr_index,
   input logic [1:0] csr_wdata
);

   `UHPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response dropped or changed while stalled")
   `UHPC_ASSERT_IMPL(a_steal_reason, clock, reset, rsp_valid, rsp_data.steal == (rsp_data.reason == R_STOLEN), "steal flag and reason disagree")
   `UHPC_ASSERT_IMPL(a_nospace_op, clock, reset, rsp_valid && rsp_data.insert_no_space, rsp_data.reason == R_TABLE_OP, "no-space on a packet verdict")
   `UHPC_ASSERT_IMPL(a_reason_range, clock, reset, rsp_valid, rsp_data.reason <= R_TABLE_OP, "reason code out of range")

endmodule

bind uid_hash_packet_classifier uhpc_checker u_checker (.*);
